// ----- rtl/core/log_message_token_masker_defines.svh -----
// ----------------------------------------------------------------------------
// Log message token masker - assertion macros
// Concurrent checks, clocked on i_clk and disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef LOG_MESSAGE_TOKEN_MASKER_DEFINES_SVH
`define LOG_MESSAGE_TOKEN_MASKER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LMTM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LMTM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/lmtm_pkg.sv -----
// ----------------------------------------------------------------------------
// lmtm_pkg
// Shared types, codes and helpers for the log message token masker.
// ----------------------------------------------------------------------------
package lmtm_pkg;

    localparam int TOK_LEN_W  = 6;
    localparam int BANK_DEPTH = 1 << TOK_LEN_W;
    localparam int RAM_DEPTH  = 2 * BANK_DEPTH;
    localparam int RAM_AW     = TOK_LEN_W + 1;

    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_COPY = 2'd1;
    localparam logic [1:0] KIND_STAR = 2'd2;
    localparam logic [1:0] KIND_OVF  = 2'd3;

    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_STAR  = 8'h2A;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_NUL   = 8'h00;

    typedef struct packed {
        logic                 sp;
        logic [1:0]           kind;
        logic [TOK_LEN_W-1:0] len;
        logic                 bank;
        logic                 eom;
    } t_cmd;

    typedef struct packed {
        logic valid;
        logic bank;
    } t_release;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    endfunction

endpackage

// ----- rtl/core/lmtm_ram.sv -----
// ----------------------------------------------------------------------------
// lmtm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lmtm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/core/lmtm_front.sv -----
// ----------------------------------------------------------------------------
// lmtm_front
// Accepts message bytes, tracks the open token, writes token bytes into the
// current buffer bank and queues one emit command per token end or message end.
// ----------------------------------------------------------------------------
`include "log_message_token_masker_defines.svh"

module lmtm_front import lmtm_pkg::*; #(
    parameter int TOKEN_MAX = 63
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [7:0]        i_s_tdata,
    input  logic              i_s_tlast,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [15:0]       i_cfg_data,
    input  t_q_status         i_q_status,
    output logic              o_push,
    output t_cmd              o_cmd,
    output logic              o_wr_en,
    output logic [RAM_AW-1:0] o_wr_addr,
    output logic [7:0]        o_wr_data,
    input  t_release          i_release
);

    localparam logic [TOK_LEN_W-1:0] LEN_MAX = TOK_LEN_W'(TOKEN_MAX);
    localparam logic [TOK_LEN_W-1:0] LEN_ONE = TOK_LEN_W'(1);

    logic [15:0]          r_max_len, n_max_len;
    logic [15:0]          r_seen,    n_seen;
    logic [TOK_LEN_W-1:0] r_len,     n_len;
    logic                 r_ovf,     n_ovf;
    logic                 r_digit,   n_digit;
    logic                 r_sp,      n_sp;
    logic                 r_started, n_started;
    logic                 r_bank,    n_bank;
    logic [1:0]           r_busy,    n_busy;

    logic                 accept;
    logic                 considered;
    logic                 ws;
    logic                 tok_byte;
    logic                 room;
    logic [TOK_LEN_W-1:0] len_a;
    logic                 ovf_a;
    logic                 digit_a;
    logic                 flush;
    logic                 copy_push;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = !i_q_status.full && !r_busy[r_bank];

    assign accept     = i_s_tvalid && o_s_tready;
    assign considered = r_seen < r_max_len;
    assign ws         = is_ws(i_s_tdata);
    assign tok_byte   = considered && !ws;
    assign room       = r_len < LEN_MAX;

    assign o_wr_en   = accept && tok_byte && room;
    assign o_wr_addr = {r_bank, r_len};
    assign o_wr_data = i_s_tdata;

    assign len_a   = o_wr_en ? r_len + LEN_ONE : r_len;
    assign ovf_a   = r_ovf || (accept && tok_byte && !room);
    assign digit_a = r_digit || (tok_byte && is_digit(i_s_tdata));

    assign flush  = accept && ((len_a != '0) || ovf_a) && ((considered && ws) || i_s_tlast);
    assign o_push = flush || (accept && i_s_tlast);

    always_comb begin
        o_cmd.sp   = r_sp;
        o_cmd.len  = len_a;
        o_cmd.bank = r_bank;
        o_cmd.eom  = i_s_tlast;
        priority if (!flush) begin
            o_cmd.kind = KIND_NONE;
        end else if (ovf_a) begin
            o_cmd.kind = KIND_OVF;
        end else if (digit_a) begin
            o_cmd.kind = KIND_STAR;
        end else begin
            o_cmd.kind = KIND_COPY;
        end
    end

    assign copy_push = o_push && (o_cmd.kind == KIND_COPY);

    always_comb begin
        n_max_len = i_cfg_valid ? i_cfg_data : r_max_len;
        n_seen    = r_seen;
        n_len     = r_len;
        n_ovf     = r_ovf;
        n_digit   = r_digit;
        n_sp      = r_sp;
        n_started = r_started;
        n_bank    = copy_push ? !r_bank : r_bank;
        n_busy    = r_busy;
        if (i_release.valid) begin
            n_busy[i_release.bank] = 1'b0;
        end
        if (copy_push) begin
            n_busy[r_bank] = 1'b1;
        end
        if (accept) begin
            if (i_s_tlast) begin
                n_seen    = '0;
                n_len     = '0;
                n_ovf     = 1'b0;
                n_digit   = 1'b0;
                n_sp      = 1'b0;
                n_started = 1'b0;
            end else begin
                n_seen = considered ? r_seen + 16'd1 : r_seen;
                if (flush) begin
                    n_len     = '0;
                    n_ovf     = 1'b0;
                    n_digit   = 1'b0;
                    n_started = 1'b1;
                    n_sp      = 1'b1;
                end else begin
                    n_len   = len_a;
                    n_ovf   = ovf_a;
                    n_digit = digit_a;
                    if (considered && ws) begin
                        n_sp = r_sp || r_started;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= 16'd512;
            r_seen    <= '0;
            r_len     <= '0;
            r_ovf     <= 1'b0;
            r_digit   <= 1'b0;
            r_sp      <= 1'b0;
            r_started <= 1'b0;
            r_bank    <= 1'b0;
            r_busy    <= '0;
        end else begin
            r_max_len <= n_max_len;
            r_seen    <= n_seen;
            r_len     <= n_len;
            r_ovf     <= n_ovf;
            r_digit   <= n_digit;
            r_sp      <= n_sp;
            r_started <= n_started;
            r_bank    <= n_bank;
            r_busy    <= n_busy;
        end
    end

    `LMTM_ASSERT_NOW(a_push_room, o_push, !i_q_status.full, "command pushed into full queue")
    `LMTM_ASSERT_NOW(a_wr_free_bank, o_wr_en, !r_busy[r_bank], "token write into busy bank")
    `LMTM_ASSERT_NOW(a_len_bound, 1'b1, r_len <= LEN_MAX, "token length beyond bound")
    `LMTM_ASSERT_NEXT(a_eom_clear, accept && i_s_tlast, (r_seen == '0) && (r_len == '0),
        "message state not cleared at end")

endmodule

// ----- rtl/core/lmtm_cmd_q.sv -----
// ----------------------------------------------------------------------------
// lmtm_cmd_q
// Two-entry command queue between the byte front end and the emit back end.
// ----------------------------------------------------------------------------
module lmtm_cmd_q import lmtm_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_cmd      i_cmd,
    input  logic      i_pop,
    output t_cmd      o_head,
    output t_q_status o_status
);

    t_cmd       r_mem [2];
    logic       r_wr_ptr, n_wr_ptr;
    logic       r_rd_ptr, n_rd_ptr;
    logic [1:0] r_count,  n_count;

    assign o_head          = r_mem[r_rd_ptr];
    assign o_status.full   = r_count == 2'd2;
    assign o_status.empty  = r_count == 2'd0;

    always_comb begin
        n_wr_ptr = i_push ? !r_wr_ptr : r_wr_ptr;
        n_rd_ptr = i_pop ? !r_rd_ptr : r_rd_ptr;
        n_count  = r_count + {1'b0, i_push} - {1'b0, i_pop};
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

// ----- rtl/core/lmtm_back.sv -----
// ----------------------------------------------------------------------------
// lmtm_back
// Pops emit commands and drives the result stream one character per cycle while
// emitting and the output is ready, reading buffered token bytes from the token RAM.
// ----------------------------------------------------------------------------
`include "log_message_token_masker_defines.svh"

module lmtm_back import lmtm_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_q_status         i_q_status,
    input  t_cmd              i_head,
    output logic              o_pop,
    output logic [RAM_AW-1:0] o_rd_addr,
    input  logic [7:0]        i_rd_data,
    output t_release          o_release,
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [15:0]       o_m_tdata,   // [7:0] out_char, [8] last_of_run
    output logic              o_m_tlast,   // end_of_message
    output logic [1:0]        o_m_tuser    // [0] char_valid, [1] token_overflow
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EMIT = 1'b1;
    localparam logic [TOK_LEN_W-1:0] LEN_ONE = TOK_LEN_W'(1);

    logic                 r_state, n_state;
    logic                 r_sp,    n_sp;
    logic [1:0]           r_kind;
    logic [TOK_LEN_W-1:0] r_len;
    logic [TOK_LEN_W-1:0] r_idx,   n_idx;
    logic                 r_bank;
    logic                 r_eom;

    logic                 r_out_valid, n_out_valid;
    logic [7:0]           r_char;
    logic                 r_cv;
    logic                 r_eom_o;
    logic                 r_ovf;
    logic                 r_lor;

    logic                 slot_free;
    logic                 emit;
    logic                 last_copy;
    logic                 fin;
    logic                 advance;
    logic [7:0]           e_char;
    logic                 e_cv;
    logic                 e_ovf;

    assign slot_free = !r_out_valid || i_m_tready;
    assign emit      = (r_state == ST_EMIT) && slot_free;
    assign o_pop     = (r_state == ST_IDLE) && !i_q_status.empty;
    assign last_copy = r_idx == (r_len - LEN_ONE);
    assign fin       = emit && !r_sp && ((r_kind != KIND_COPY) || last_copy);
    assign advance   = emit && !r_sp && (r_kind == KIND_COPY) && !last_copy;

    assign n_idx     = o_pop ? '0 : (advance ? r_idx + LEN_ONE : r_idx);
    assign o_rd_addr = {(o_pop ? i_head.bank : r_bank), n_idx};

    assign o_release.valid = fin && (r_kind == KIND_COPY);
    assign o_release.bank  = r_bank;

    always_comb begin
        e_char = CHAR_NUL;
        e_cv   = 1'b1;
        e_ovf  = 1'b0;
        if (r_sp) begin
            e_char = CHAR_SPACE;
        end else begin
            unique case (r_kind)
                KIND_NONE: begin
                    e_cv = 1'b0;
                end
                KIND_COPY: begin
                    e_char = i_rd_data;
                end
                KIND_STAR: begin
                    e_char = CHAR_STAR;
                end
                KIND_OVF: begin
                    e_char = CHAR_STAR;
                    e_ovf  = 1'b1;
                end
                default: begin
                    e_cv = 1'b0;
                end
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        n_sp    = r_sp;
        if (o_pop) begin
            n_state = ST_EMIT;
            n_sp    = i_head.sp && (i_head.kind != KIND_NONE);
        end else if (emit) begin
            n_sp = 1'b0;
            if (fin) begin
                n_state = ST_IDLE;
            end
        end
        n_out_valid = emit ? 1'b1 : (i_m_tready ? 1'b0 : r_out_valid);
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_kind <= i_head.kind;
            r_len  <= i_head.len;
            r_bank <= i_head.bank;
            r_eom  <= i_head.eom;
        end
        r_idx <= n_idx;
        if (emit) begin
            r_char  <= e_char;
            r_cv    <= e_cv;
            r_ovf   <= e_ovf;
            r_lor   <= fin;
            r_eom_o <= fin && r_eom;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_sp        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sp        <= n_sp;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {7'd0, r_lor, r_char};
    assign o_m_tlast  = r_eom_o;
    assign o_m_tuser  = {r_ovf, r_cv};

    `LMTM_ASSERT_NOW(a_bare_is_end, r_out_valid && !r_cv, r_eom_o && r_lor,
        "bare result without end of message")
    `LMTM_ASSERT_NOW(a_ovf_is_star, r_out_valid && r_ovf, r_cv && (r_char == CHAR_STAR),
        "overflow flag on a non-star result")
    `LMTM_ASSERT_NOW(a_eom_is_lor, r_out_valid && r_eom_o, r_lor,
        "end of message not last of run")
    `LMTM_ASSERT_NEXT(a_release_idle, o_release.valid, r_state == ST_IDLE,
        "bank released while still emitting")

endmodule

// ----- rtl/core/log_message_token_masker.sv -----
// ----------------------------------------------------------------------------
// log_message_token_masker
// Path: ending byte -> command queue -> back end emit state -> output register.
// Throughput: 1 byte per cycle in; results 1 per cycle while emitting, with a
//   return to idle to pop each command; input stalls while both token buffer
//   banks await emission or the two-entry command queue is full.
// Reset: synchronous active-low i_rst_n clears control state, max_len = 512;
//   token RAM is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module log_message_token_masker import lmtm_pkg::*; #(
    parameter int TOKEN_MAX = 63
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] in_byte
    input  logic        i_s_tlast,   // in_last
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // [7:0] out_char, [8] last_of_run
    output logic        o_m_tlast,   // end_of_message
    output logic [1:0]  o_m_tuser,   // [0] char_valid, [1] token_overflow
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data   // max_len
);

    logic              push;
    logic              pop;
    t_cmd              cmd;
    t_cmd              head;
    t_q_status         q_status;
    t_release          release_bank;
    logic              wr_en;
    logic [RAM_AW-1:0] wr_addr;
    logic [7:0]        wr_data;
    logic [RAM_AW-1:0] rd_addr;
    logic [7:0]        rd_data;

    lmtm_front #(
        .TOKEN_MAX (TOKEN_MAX)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tlast   (i_s_tlast),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_q_status  (q_status),
        .o_push      (push),
        .o_cmd       (cmd),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data),
        .i_release   (release_bank)
    );

    lmtm_cmd_q u_cmd_q (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_cmd    (cmd),
        .i_pop    (pop),
        .o_head   (head),
        .o_status (q_status)
    );

    lmtm_ram #(
        .WIDTH (8),
        .DEPTH (RAM_DEPTH)
    ) u_token_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    lmtm_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_status (q_status),
        .i_head     (head),
        .o_pop      (pop),
        .o_rd_addr  (rd_addr),
        .i_rd_data  (rd_data),
        .o_release  (release_bank),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)
    );

endmodule
